>>> hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  // default depth of the pattern table
  localparam int TableDepthDef = 64;

  // width of step counters: covers 2 * 255 blinks and the largest table
  localparam int StepW = 11;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_LOAD   = 3'd1,
    KIND_STEADY = 3'd2,
    KIND_BLINK  = 3'd3,
    KIND_COUNT  = 3'd4,
    KIND_PLAY   = 3'd5,
    KIND_STOP   = 3'd6
  } kind_t;

  typedef enum logic {
    REG_TICK_MS     = 1'b0,
    REG_BUZZER_KIND = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tone_freq;
    logic [15:0] hold_ms;
    logic        loop_on;
    logic [7:0]  repeat_count;
    logic [5:0]  entry_index;
    logic [15:0] entry_time;
    logic [15:0] entry_freq;
    logic [6:0]  seq_length;
  } in_word_t;

  typedef struct packed {
    logic        drive_on;
    logic [15:0] drive_freq;
    logic        playing;
    logic        finished;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [15:0] time_ms;
    logic [15:0] freq;
  } entry_t;

  // table write request
  typedef struct packed {
    logic       en;
    logic [5:0] index;
    entry_t     entry;
  } tbl_wr_t;

endpackage

>>> hw/rtl/bps_table.sv
// ----------------------------------------------------------------------------
// bps_table
// Pattern table memory with a registered read, same-cycle write forwarding
// and a copy of entry zero for table start.
// ----------------------------------------------------------------------------
module bps_table #(
  parameter int TABLE_DEPTH = bps_pkg::TableDepthDef,
  parameter int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  bps_pkg::tbl_wr_t wr,
  input  logic [IdxW-1:0]  rd_addr,
  output bps_pkg::entry_t  next_entry,
  output bps_pkg::entry_t  first_entry
);
  import bps_pkg::*;

  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_q;
  entry_t          byp_data;
  entry_t          entry0;
  logic            byp;
  logic [IdxW-1:0] waddr;

  assign waddr = IdxW'(wr.index);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.entry;
    end
    rd_q     <= mem[rd_addr];
    byp_data <= wr.entry;
    if (wr.en && waddr == '0) begin
      entry0 <= wr.entry;
    end
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= wr.en && (waddr == rd_addr);
    end
  end

  assign next_entry  = byp ? byp_data : rd_q;
  assign first_entry = entry0;

endmodule

>>> hw/rtl/bps_ctrl.sv
// ----------------------------------------------------------------------------
// bps_ctrl
// Pattern state, configuration registers and per-word update.
// ----------------------------------------------------------------------------
module bps_ctrl #(
  parameter int TABLE_DEPTH = bps_pkg::TableDepthDef,
  parameter int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  bps_pkg::in_word_t  item,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data,
  input  bps_pkg::entry_t    next_entry,
  input  bps_pkg::entry_t    first_entry,
  output logic [IdxW-1:0]    rd_addr,
  output bps_pkg::tbl_wr_t   wr,
  output bps_pkg::out_word_t res
);
  import bps_pkg::*;

  localparam logic [StepW-1:0] DepthL = StepW'(TABLE_DEPTH);

  logic [9:0]       tick_ms;
  logic             buzzer_kind;

  logic [31:0]      elapsed_ms, elapsed_ms_next;
  logic [StepW-1:0] step_index, step_index_next;
  logic [StepW-1:0] step_total, step_total_next;
  logic [15:0]      hold_limit, hold_limit_next;
  logic [15:0]      current_freq, current_freq_next;
  logic             looping, looping_next;
  logic             table_mode, table_mode_next;
  logic             active_flag, active_flag_next;
  logic             level, level_next;
  logic             fin;

  logic [32:0]      sum;
  logic [31:0]      el;
  logic [StepW-1:0] idx1;
  logic [StepW-1:0] slen;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms     <= 10'd1;
      buzzer_kind <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TICK_MS:     tick_ms <= cfg_data;
        REG_BUZZER_KIND: buzzer_kind <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    elapsed_ms_next   = elapsed_ms;
    step_index_next   = step_index;
    step_total_next   = step_total;
    hold_limit_next   = hold_limit;
    current_freq_next = current_freq;
    looping_next      = looping;
    table_mode_next   = table_mode;
    active_flag_next  = active_flag;
    level_next        = level;
    fin               = 1'b0;

    sum  = {1'b0, elapsed_ms} + 33'(tick_ms);
    el   = sum[32] ? '1 : sum[31:0];
    idx1 = step_index + StepW'(1);
    slen = (StepW'(item.seq_length) > DepthL) ? DepthL : StepW'(item.seq_length);

    wr.en    = 1'b0;
    wr.index = item.entry_index;
    wr.entry = '{time_ms: item.entry_time, freq: item.entry_freq};

    if (acc) begin
      case (kind_t'(item.kind))
        KIND_TICK: begin
          elapsed_ms_next = el;
          if (active_flag && step_total != '0 && el > 32'(hold_limit)) begin
            elapsed_ms_next = '0;
            if (idx1 < step_total) begin
              if (!table_mode) begin
                step_index_next = looping ? StepW'(idx1[0]) : idx1;
                level_next      = ~step_index_next[0];
              end else begin
                step_index_next   = idx1;
                hold_limit_next   = next_entry.time_ms;
                current_freq_next = next_entry.freq;
                level_next        = 1'b1;
              end
            end else begin
              step_index_next  = idx1;
              level_next       = 1'b0;
              active_flag_next = 1'b0;
              fin              = 1'b1;
            end
          end
        end
        KIND_LOAD: begin
          wr.en = StepW'(item.entry_index) < DepthL;
        end
        KIND_STEADY: begin
          active_flag_next  = 1'b1;
          looping_next      = 1'b0;
          step_total_next   = '0;
          level_next        = 1'b1;
          current_freq_next = item.tone_freq;
        end
        KIND_BLINK, KIND_COUNT: begin
          step_index_next   = '0;
          elapsed_ms_next   = '0;
          hold_limit_next   = item.hold_ms;
          table_mode_next   = 1'b0;
          active_flag_next  = 1'b1;
          level_next        = 1'b1;
          current_freq_next = item.tone_freq;
          if (kind_t'(item.kind) == KIND_BLINK) begin
            looping_next    = item.loop_on;
            step_total_next = item.loop_on ? StepW'(3) : StepW'(2);
          end else begin
            looping_next    = 1'b0;
            step_total_next = StepW'({item.repeat_count, 1'b0});
          end
        end
        KIND_PLAY: begin
          step_total_next   = slen;
          step_index_next   = '0;
          looping_next      = 1'b0;
          table_mode_next   = 1'b1;
          active_flag_next  = 1'b1;
          level_next        = 1'b1;
          hold_limit_next   = first_entry.time_ms;
          current_freq_next = first_entry.freq;
        end
        KIND_STOP: begin
          active_flag_next = 1'b0;
          level_next       = 1'b0;
        end
        default: ;
      endcase
    end

    // prefetch the entry the next advance would take
    rd_addr = IdxW'(step_index_next + StepW'(1));

    res.drive_on   = level_next;
    res.drive_freq = (level_next && buzzer_kind) ? current_freq_next : 16'd0;
    res.playing    = active_flag_next;
    res.finished   = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms   <= '0;
      step_index   <= '0;
      step_total   <= '0;
      hold_limit   <= '0;
      current_freq <= '0;
      looping      <= 1'b0;
      table_mode   <= 1'b0;
      active_flag  <= 1'b0;
      level        <= 1'b0;
    end else begin
      elapsed_ms   <= elapsed_ms_next;
      step_index   <= step_index_next;
      step_total   <= step_total_next;
      hold_limit   <= hold_limit_next;
      current_freq <= current_freq_next;
      looping      <= looping_next;
      table_mode   <= table_mode_next;
      active_flag  <= active_flag_next;
      level        <= level_next;
    end
  end

endmodule

>>> hw/rtl/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Command-driven buzzer pattern engine with a pattern table.
// ----------------------------------------------------------------------------
// Every accepted input word is one command (tick, table load, steady on,
// blink, counted blinks, table play, stop) and yields exactly one output
// word with the drive level, tone and status. A word is taken in every
// unstalled cycle; the rate is set by the state update, which performs
// one saturating add of tick_ms and one compare against the hold time per
// word. The pattern table sits in a synchronous memory; the entry
// following the current step is read ahead every cycle, and a load that
// hits the address being read is forwarded, so table play never waits.
// Entry zero is also kept in a register so that table play can start at
// once. Table entries hold garbage until loaded. Configuration writes
// (tick_ms, buzzer_kind) are to be made only while the block is idle,
// which the block does not enforce. An output register plus a skid stage
// decouple the two sides: in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer #(
  parameter int TABLE_DEPTH = bps_pkg::TableDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bps_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bps_pkg::out_word_t out_data,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data
);
  import bps_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic            acc;
  logic [IdxW-1:0] rd_addr;
  tbl_wr_t         wr;
  entry_t          next_entry;
  entry_t          first_entry;
  out_word_t       res;
  out_word_t       skid_data;
  logic            skid_valid;

  // take a word whenever the skid stage is free
  assign in_stall = skid_valid;
  assign acc      = in_valid && !skid_valid;

  bps_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IdxW       (IdxW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .next_entry (next_entry),
    .first_entry(first_entry)
  );

  bps_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .item       (in_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .next_entry (next_entry),
    .first_entry(first_entry),
    .rd_addr    (rd_addr),
    .wr         (wr),
    .res        (res)
  );

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (acc) begin
      if (out_valid && out_stall) begin
        // output held: park the new word in the skid stage
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      // drained: refill from the skid stage or drop valid
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (out_valid && out_stall) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (out_valid && !out_stall && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule
